[rtl/ps2sc_pkg.sv]
// Package for the PS/2 set 1 scan code decoder with character ring buffer.
// Holds item types, scan code constants and the key lookup tables.
// No dependencies.
package ps2sc_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       buffer_nonempty;
    logic       dropped;
  } out_item_t;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_UP     = 3'd0,
    REG_CODE_DOWN   = 3'd1,
    REG_CODE_LEFT   = 3'd2,
    REG_CODE_RIGHT  = 3'd3,
    REG_CODE_ESCAPE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } cfg_item_t;

  typedef struct packed {
    logic       req;
    logic [7:0] ch;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic nonempty_nxt;
  } ring_status_t;

  localparam logic [7:0] SC_PREFIX    = 8'hE0;
  localparam logic [7:0] SC_RELEASE   = 8'h80;
  localparam logic [7:0] SC_CODE_MASK = 8'h7F;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_CAPS      = 8'h3A;
  localparam logic [7:0] SC_ESCAPE    = 8'h01;
  localparam logic [7:0] SC_UP        = 8'h48;
  localparam logic [7:0] SC_DOWN      = 8'h50;
  localparam logic [7:0] SC_LEFT      = 8'h4B;
  localparam logic [7:0] SC_RIGHT     = 8'h4D;

  localparam int unsigned MAP_LEN = 58;
  localparam logic [7:0]  CHAR_A  = 8'h61;
  localparam logic [7:0]  CHAR_Z  = 8'h7A;

  localparam logic [7:0] MAP_PLAIN [MAP_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08,
    8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F,
    8'h70, 8'h5B, 8'h5D, 8'h0A,
    8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C,
    8'h3B, 8'h27, 8'h60,
    8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
    8'h2E, 8'h2F, 8'h00,
    8'h2A, 8'h00, 8'h20
  };

  localparam logic [7:0] MAP_SHIFTED [MAP_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08,
    8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F,
    8'h50, 8'h7B, 8'h7D, 8'h0A,
    8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C,
    8'h3A, 8'h22, 8'h7E,
    8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
    8'h3E, 8'h3F, 8'h00,
    8'h2A, 8'h00, 8'h20
  };

endpackage

[rtl/ps2sc_chan_if.sv]
// Valid/ready channel interface carrying one item of payload type T.
// No dependencies.
interface ps2sc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/ps2_scancode_to_char_fifo.sv]
// Top level: PS/2 set 1 scan code decoder feeding a character ring buffer.
// Depends on ps2sc_pkg, ps2sc_chan_if, ps2sc_decode, ps2sc_ring.
//
//   port   dir  payload                                       notes
//   in_i   in   mode, scan_byte                               0 = scan byte, 1 = read
//   out_o  out  char_valid, char_out, buffer_nonempty, dropped  one per input item
//   cfg_i  in   index (0..4), data                            always ready
//
// One item per cycle while out_o is ready; each result appears in the cycle after its item is accepted,
// with read data from the single registered read port of the character memory.
// Reset clears pointers and key state and sets the code registers to their defaults; memory is not cleared.
// in_i.ready follows out_o.ready while a result is held, so the input stalls only while the output does.
module ps2_scancode_to_char_fifo
  import ps2sc_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ps2sc_chan_if.sink   in_i,
  ps2sc_chan_if.source out_o,
  ps2sc_chan_if.sink   cfg_i
);

  in_item_t     in_item;
  cfg_item_t    cfg_item;
  logic         accept, scan_en, pop;
  push_t        push;
  ring_status_t ring_st;
  logic [7:0]   rdata;
  logic         out_valid_q;
  logic         char_valid_q, nonempty_q, dropped_q;
  out_item_t    out_item;

  assign in_item   = in_i.payload;
  assign cfg_item  = cfg_i.payload;
  assign cfg_i.ready = 1'b1;

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;
  assign scan_en    = accept & ~in_item.mode;
  assign pop        = accept & in_item.mode;

  ps2sc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (scan_en),
    .scan_byte_i (in_item.scan_byte),
    .cfg_we_i    (cfg_i.valid),
    .cfg_i       (cfg_item),
    .push_o      (push)
  );

  ps2sc_ring #(
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (ring_st),
    .rdata_o  (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      char_valid_q <= 1'b0;
      nonempty_q   <= 1'b0;
      dropped_q    <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
      if (accept) begin
        char_valid_q <= pop & ~ring_st.empty;
        nonempty_q   <= ring_st.nonempty_nxt;
        dropped_q    <= push.req & ring_st.full;
      end
    end
  end

  always_comb begin
    out_item.char_valid      = char_valid_q;
    out_item.char_out        = char_valid_q ? rdata : 8'h00;
    out_item.buffer_nonempty = nonempty_q;
    out_item.dropped         = dropped_q;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item;

endmodule

[rtl/ps2sc_decode.sv]
// Scan code decoder: prefix, shift and caps state, arrow/escape code registers.
// Produces at most one character push per scan byte. Uses ps2sc_pkg.
module ps2sc_decode
  import ps2sc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] scan_byte_i,
  input  logic       cfg_we_i,
  input  cfg_item_t  cfg_i,
  output push_t      push_o
);

  logic       prefix_q, prefix_d;
  logic       shift_q, shift_d;
  logic       caps_q, caps_d;
  logic [7:0] code_up_q, code_down_q, code_left_q, code_right_q, code_esc_q;
  logic [7:0] low7, plain_ch, shift_ch;
  logic       in_map, is_letter, shift_sel;
  push_t      push;

  assign low7      = scan_byte_i & SC_CODE_MASK;
  assign in_map    = scan_byte_i < 8'(MAP_LEN);
  assign plain_ch  = in_map ? MAP_PLAIN[scan_byte_i[5:0]] : 8'h00;
  assign shift_ch  = in_map ? MAP_SHIFTED[scan_byte_i[5:0]] : 8'h00;
  assign is_letter = (plain_ch >= CHAR_A) && (plain_ch <= CHAR_Z);
  assign shift_sel = shift_q ^ (caps_q & is_letter);

  always_comb begin
    prefix_d = prefix_q;
    shift_d  = shift_q;
    caps_d   = caps_q;
    push     = '0;
    if (scan_byte_i == SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if ((scan_byte_i & SC_RELEASE) == 8'h00) begin
        case (scan_byte_i)
          SC_UP:    push = '{req: 1'b1, ch: code_up_q};
          SC_DOWN:  push = '{req: 1'b1, ch: code_down_q};
          SC_LEFT:  push = '{req: 1'b1, ch: code_left_q};
          SC_RIGHT: push = '{req: 1'b1, ch: code_right_q};
          default:  push = '0;
        endcase
      end
    end else if ((scan_byte_i & SC_RELEASE) != 8'h00) begin
      if (low7 == SC_LSHIFT || low7 == SC_RSHIFT) begin
        shift_d = 1'b0;
      end
    end else if (scan_byte_i == SC_LSHIFT || scan_byte_i == SC_RSHIFT) begin
      shift_d = 1'b1;
    end else if (scan_byte_i == SC_CAPS) begin
      caps_d = ~caps_q;
    end else if (scan_byte_i == SC_ESCAPE) begin
      push = '{req: 1'b1, ch: code_esc_q};
    end else begin
      push.ch  = shift_sel ? shift_ch : plain_ch;
      push.req = push.ch != 8'h00;
    end
  end

  assign push_o = '{req: push.req & en_i, ch: push.ch};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
    end else if (en_i) begin
      prefix_q <= prefix_d;
      shift_q  <= shift_d;
      caps_q   <= caps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_up_q    <= 8'd128;
      code_down_q  <= 8'd129;
      code_left_q  <= 8'd130;
      code_right_q <= 8'd131;
      code_esc_q   <= 8'd27;
    end else if (cfg_we_i) begin
      case (cfg_i.index)
        REG_CODE_UP:     code_up_q    <= cfg_i.data;
        REG_CODE_DOWN:   code_down_q  <= cfg_i.data;
        REG_CODE_LEFT:   code_left_q  <= cfg_i.data;
        REG_CODE_RIGHT:  code_right_q <= cfg_i.data;
        REG_CODE_ESCAPE: code_esc_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/ps2sc_ring.sv]
// Character ring buffer: one synchronous memory, head and tail pointers.
// One slot stays empty; read data is registered. Uses ps2sc_pkg.
module ps2sc_ring
  import ps2sc_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  push_t        push_i,
  input  logic         pop_i,
  output ring_status_t status_o,
  output logic [7:0]   rdata_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] head_q, tail_q, head_inc, tail_inc;
  logic [7:0]    rdata_q;
  logic          empty, full, do_push, do_pop;

  assign head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign tail_inc = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
  assign empty    = head_q == tail_q;
  assign full     = tail_inc == head_q;
  assign do_push  = push_i.req & ~full;
  assign do_pop   = pop_i & ~empty;

  always_comb begin
    status_o.full  = full;
    status_o.empty = empty;
    if (do_pop) begin
      status_o.nonempty_nxt = head_inc != tail_q;
    end else if (do_push) begin
      status_o.nonempty_nxt = 1'b1;
    end else begin
      status_o.nonempty_nxt = ~empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (do_pop) begin
        head_q <= head_inc;
      end
      if (do_push) begin
        tail_q <= tail_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[tail_q] <= push_i.ch;
    end
    if (do_pop) begin
      rdata_q <= mem[head_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[verif/ps2_scancode_to_char_fifo_test.sv]
`timescale 1ns / 1ps
// Testbench for ps2_scancode_to_char_fifo: drives scan code bytes and character reads,
// predicts each result with its own key decoder and ring buffer, checks results in order.
// Depends on ps2sc_pkg, ps2sc_chan_if and the ps2_scancode_to_char_fifo RTL.
module ps2_scancode_to_char_fifo_test;
  import ps2sc_pkg::*;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } key_op_e;

  typedef struct {
    in_item_t item;
    bit       wait_drained;
  } key_item_t;

  localparam int unsigned RING_DEPTH    = 256;
  localparam int unsigned KEY_TABLE_LEN = 58;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;

  localparam logic [7:0] SCAN_EXT      = 8'hE0;
  localparam logic [7:0] SCAN_BREAK    = 8'h80;
  localparam logic [7:0] SCAN_LSHIFT   = 8'h2A;
  localparam logic [7:0] SCAN_RSHIFT   = 8'h36;
  localparam logic [7:0] SCAN_CAPS     = 8'h3A;
  localparam logic [7:0] SCAN_ESC      = 8'h01;
  localparam logic [7:0] SCAN_UP       = 8'h48;
  localparam logic [7:0] SCAN_DOWN     = 8'h50;
  localparam logic [7:0] SCAN_LEFT     = 8'h4B;
  localparam logic [7:0] SCAN_RIGHT    = 8'h4D;
  localparam logic [7:0] SCAN_UNMAPPED = 8'h00;
  localparam logic [7:0] SCAN_KEY_1    = 8'h02;
  localparam logic [7:0] SCAN_KEY_A    = 8'h1E;
  localparam logic [7:0] SCAN_SPACE    = 8'h39;
  localparam logic [7:0] SCAN_F1       = 8'h3B;
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;

  logic [7:0] plain_keys [KEY_TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  logic [7:0] shifted_keys [KEY_TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  logic [7:0] arrow_keys [4] = '{SCAN_UP, SCAN_DOWN, SCAN_LEFT, SCAN_RIGHT};

  logic clk_i;
  logic rst_ni;

  ps2sc_chan_if #(.T(in_item_t))  in_if  ();
  ps2sc_chan_if #(.T(out_item_t)) out_if ();
  ps2sc_chan_if #(.T(cfg_item_t)) cfg_if ();

  ps2_scancode_to_char_fifo uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  bit          ext_pending = 1'b0;
  bit          shift_down = 1'b0;
  bit          caps_active = 1'b0;
  logic [7:0]  code_reg [5] = '{8'd128, 8'd129, 8'd130, 8'd131, 8'd27};

  key_item_t   pending_keys [$];
  out_item_t   expected_chars [$];
  key_item_t   next_key;
  out_item_t   want;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned stall_draw = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned queued_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic out_item_t next_char_result(in_item_t it);
    out_item_t  res;
    logic [7:0] sb;
    logic [7:0] plain;
    logic [7:0] ch;
    bit         emit;
    bit         shift_sel;
    res = '0;
    emit = 1'b0;
    ch = '0;
    sb = it.scan_byte;
    if (key_op_e'(it.mode) == OP_READ) begin
      if (ring_head != ring_tail) begin
        res.char_valid = 1'b1;
        res.char_out = ring_mem[ring_head];
        ring_head = (ring_head + 1) % RING_DEPTH;
      end
    end else if (sb == SCAN_EXT) begin
      ext_pending = 1'b1;
    end else if (ext_pending) begin
      ext_pending = 1'b0;
      emit = 1'b1;
      case (sb)
        SCAN_UP:    ch = code_reg[REG_CODE_UP];
        SCAN_DOWN:  ch = code_reg[REG_CODE_DOWN];
        SCAN_LEFT:  ch = code_reg[REG_CODE_LEFT];
        SCAN_RIGHT: ch = code_reg[REG_CODE_RIGHT];
        default:    emit = 1'b0;
      endcase
    end else if (sb & SCAN_BREAK) begin
      if ((sb & ~SCAN_BREAK) == SCAN_LSHIFT || (sb & ~SCAN_BREAK) == SCAN_RSHIFT)
        shift_down = 1'b0;
    end else if (sb == SCAN_LSHIFT || sb == SCAN_RSHIFT) begin
      shift_down = 1'b1;
    end else if (sb == SCAN_CAPS) begin
      caps_active = !caps_active;
    end else if (sb == SCAN_ESC) begin
      emit = 1'b1;
      ch = code_reg[REG_CODE_ESCAPE];
    end else if (sb < KEY_TABLE_LEN) begin
      plain = plain_keys[sb];
      shift_sel = shift_down ^ (caps_active && plain >= CHAR_LOWER_A && plain <= CHAR_LOWER_Z);
      ch = shift_sel ? shifted_keys[sb] : plain;
      emit = (ch != 8'h00);
    end
    if (emit) begin
      if ((ring_tail + 1) % RING_DEPTH == ring_head) begin
        res.dropped = 1'b1;
      end else begin
        ring_mem[ring_tail] = ch;
        ring_tail = (ring_tail + 1) % RING_DEPTH;
      end
    end
    res.buffer_nonempty = (ring_head != ring_tail);
    return res;
  endfunction

  function automatic int unsigned pick_idle(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) != 0) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // sender: hold the item until taken, then idle for a random gap; a wait_drained item waits for all results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      send_gap <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_keys.size() != 0 &&
                   !(pending_keys[0].wait_drained &&
                     (in_if.valid || expected_chars.size() != 0))) begin
        next_key = pending_keys.pop_front();
        in_if.valid <= 1'b1;
        in_if.payload <= next_key.item;
        send_gap <= pick_idle(send_idle_pct);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: predict on every accepted item, check every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_chars.push_back(next_char_result(in_if.payload));
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          $error("result with no item pending: char_out %0h", out_if.payload.char_out);
          mismatch_count++;
        end else begin
          want = expected_chars.pop_front();
          check_field("char_valid", want.char_valid, out_if.payload.char_valid);
          check_field("char_out", want.char_out, out_if.payload.char_out);
          check_field("buffer_nonempty", want.buffer_nonempty, out_if.payload.buffer_nonempty);
          check_field("dropped", want.dropped, out_if.payload.dropped);
        end
      end
      if (recv_stall != 0) begin
        out_if.ready <= 1'b0;
        recv_stall <= recv_stall - 1;
      end else begin
        stall_draw = pick_idle(recv_stall_pct);
        out_if.ready <= (stall_draw == 0);
        recv_stall <= (stall_draw == 0) ? 0 : stall_draw - 1;
      end
    end
  end

  task automatic add_item(input key_op_e op, input logic [7:0] sb, input bit hold);
    key_item_t k;
    k.item.mode = op;
    k.item.scan_byte = sb;
    k.wait_drained = hold;
    pending_keys.push_back(k);
    queued_count++;
  endtask

  task automatic add_scan(input logic [7:0] sb);
    add_item(OP_SCAN, sb, 1'b0);
  endtask

  task automatic add_read();
    add_item(OP_READ, 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic add_keystroke();
    logic [7:0] k;
    logic [7:0] s;
    logic [7:0] other;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        k = 8'($urandom_range(KEY_TABLE_LEN - 1));
        add_scan(k);
        if ($urandom_range(1)) add_scan(k | SCAN_BREAK);
      end
      4, 5: begin
        s = $urandom_range(1) ? SCAN_LSHIFT : SCAN_RSHIFT;
        other = (s == SCAN_LSHIFT) ? SCAN_RSHIFT : SCAN_LSHIFT;
        add_scan(s);
        repeat ($urandom_range(4, 1)) add_scan(8'($urandom_range(KEY_TABLE_LEN - 1)));
        add_scan((($urandom_range(3) == 0) ? other : s) | SCAN_BREAK);
      end
      6: begin
        add_scan(SCAN_CAPS);
        add_scan(SCAN_CAPS | SCAN_BREAK);
      end
      7: begin
        k = arrow_keys[$urandom_range(3)];
        add_scan(SCAN_EXT);
        add_scan(k);
        if ($urandom_range(1)) begin
          add_scan(SCAN_EXT);
          add_scan(k | SCAN_BREAK);
        end
      end
      8: begin
        add_scan(SCAN_EXT);
        add_scan(8'($urandom_range(255)));
      end
      default: add_scan(8'($urandom_range(255)));
    endcase
  endtask

  task automatic add_mix(input int unsigned n, input int unsigned read_pct,
                         input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned target;
    target = queued_count + n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (queued_count < target) begin
      if ($urandom_range(99) < read_pct) repeat ($urandom_range(3, 1)) add_read();
      else add_keystroke();
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_keys.size() != 0 || in_if.valid || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_codes(input logic [7:0] vals [5]);
    cfg_reg_e r;
    r = r.first();
    repeat (r.num()) begin
      cfg_if.valid <= 1'b1;
      cfg_if.payload <= '{index: r, data: vals[r]};
      do @(posedge clk_i);
      while (!cfg_if.ready);
      code_reg[r] = vals[r];
      r = r.next();
    end
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] codes [5];
    rst_ni <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 30;
    recv_stall_pct = 30;
    add_item(OP_READ, 8'hFF, 1'b0);
    add_scan(SCAN_ESC);
    add_scan(SCAN_EXT);  add_scan(SCAN_UP);
    add_scan(SCAN_EXT);  add_scan(SCAN_EXT);  add_scan(SCAN_DOWN);
    add_scan(SCAN_EXT);  add_item(OP_READ, 8'h00, 1'b0);  add_scan(SCAN_LEFT);
    add_scan(SCAN_EXT);  add_scan(SCAN_RIGHT | SCAN_BREAK);
    add_scan(SCAN_LSHIFT);  add_scan(SCAN_KEY_1);  add_scan(SCAN_KEY_A);
    add_scan(SCAN_LSHIFT | SCAN_BREAK);
    add_scan(SCAN_CAPS);  add_scan(SCAN_KEY_A);  add_scan(SCAN_KEY_1);
    add_scan(SCAN_RSHIFT);  add_scan(SCAN_KEY_A);  add_scan(SCAN_RSHIFT | SCAN_BREAK);
    add_scan(SCAN_CAPS);
    add_scan(SCAN_UNMAPPED);  add_scan(SCAN_F1);  add_scan(8'hFF);  add_scan(SCAN_SPACE);
    add_mix(300, 25, 0, 0);
    wait_drained();

    codes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    write_codes(codes);
    add_mix(650, 2, 40, 20);
    add_mix(320, 90, 20, 50);
    wait_drained();

    codes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    write_codes(codes);
    add_mix(300, 30, 10, 10);
    wait_drained();

    foreach (codes[i]) codes[i] = 8'($urandom_range(255));
    write_codes(codes);
    add_mix(175, 30, 50, 40);
    add_item(OP_READ, 8'($urandom_range(255)), 1'b1);
    add_mix(175, 30, 50, 40);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
